[hw/rtl/lage_pkg.sv]
// Shared types, operation codes and helpers for the life grid engine.
package lage_pkg;

    // Width of row counters and of widened row and column compares.
    localparam int IDX_W = 11;

    typedef logic [1:0] t_op;

    localparam t_op OP_WRITE   = 2'd0;
    localparam t_op OP_ADVANCE = 2'd1;
    localparam t_op OP_READ    = 2'd2;

    typedef logic [1:0] t_cls;

    localparam t_cls CLS_DEAD  = 2'd0;
    localparam t_cls CLS_TWO   = 2'd1;
    localparam t_cls CLS_THREE = 2'd2;
    localparam t_cls CLS_OTHER = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             take;     // capture the input beat
        logic             clr;      // write a zero row into both banks at cnt
        logic             rd_seq;   // read row cnt of both banks
        logic             rd_nbr;   // read row (row + cnt - 1) of both banks
        logic             wr_cell;  // write back the row with one cell replaced
        logic             wr_gen;   // write next-generation row (cnt - 3)
        logic             flip;     // swap current and previous banks
        logic             load_out; // load the result register
        logic [IDX_W-1:0] cnt;
    } t_dp_cmd;

    // Number of set bits among eight neighbor bits.
    function automatic logic [3:0] count8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

endpackage

[hw/rtl/lage_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface lage_in_if;
    import lage_pkg::*;
    logic       valid;
    logic       ready;
    t_op        operation;
    logic [7:0] col;
    logic [6:0] row;
    logic       cell_value;

    modport source (output valid, operation, col, row, cell_value, input ready);
    modport sink (input valid, operation, col, row, cell_value, output ready);
endinterface

interface lage_out_if;
    import lage_pkg::*;
    logic       valid;
    logic       ready;
    logic       alive;
    logic [3:0] neighbour_count;
    t_cls       colour_class;
    logic       changed;

    modport source (output valid, alive, neighbour_count, colour_class, changed,
                    input ready);
    modport sink (input valid, alive, neighbour_count, colour_class, changed,
                  output ready);
endinterface

[hw/rtl/lage_ctrl.sv]
// Controller state machine: clearing pass, operation sequencing, result handshake.
module lage_ctrl #(
    parameter int GRID_ROWS = 120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lage_pkg::t_op     i_op,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output lage_pkg::t_dp_cmd o_cmd
);
    import lage_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_ROWS - 1);
    localparam logic [IDX_W-1:0] ADV_END  = IDX_W'(GRID_ROWS + 1);
    localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);
    localparam logic [IDX_W-1:0] THREE    = IDX_W'(3);
    localparam logic [IDX_W-1:0] FOUR     = IDX_W'(4);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + ONE;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_cnt == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_op)
                        OP_WRITE: begin
                            n_state = S_WRITE;
                            n_cnt   = ONE;
                        end
                        OP_ADVANCE: n_state = S_ADV;
                        OP_READ:    n_state = S_READ;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                // Fetch the addressed row, then write it back modified.
                if (r_cnt == ONE) begin
                    o_cmd.rd_nbr = 1'b1;
                end else begin
                    o_cmd.wr_cell = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                // Three neighbor rows, then a wait for the last to reach the window.
                o_cmd.rd_nbr = (r_cnt < THREE);
                if (r_cnt == THREE) begin
                    n_state = S_DONE;
                end
            end
            S_ADV: begin
                o_cmd.rd_seq = (r_cnt <= LAST_ROW);
                o_cmd.wr_gen = (r_cnt >= FOUR);
                if (r_cnt == ADV_END) begin
                    o_cmd.flip = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Result valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

[hw/rtl/lage_dp.sv]
// Datapath: two row-wide grid banks, three-row windows, rule and result logic.
module lage_dp #(
    parameter int GRID_COLS = 160,
    parameter int GRID_ROWS = 120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lage_pkg::t_dp_cmd i_cmd,
    input  lage_pkg::t_op     i_op,
    input  logic [7:0]        i_col,
    input  logic [6:0]        i_row,
    input  logic              i_cell_value,
    output logic              o_alive,
    output logic [3:0]        o_neighbour_count,
    output lage_pkg::t_cls    o_colour_class,
    output logic              o_changed
);
    import lage_pkg::*;

    localparam int AW = $clog2(GRID_ROWS);
    localparam int PW = GRID_COLS + 2;

    // Captured input beat.
    t_op        r_op;
    logic [7:0] r_col;
    logic [6:0] r_row;
    logic       r_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_op;
            r_col <= i_col;
            r_row <= i_row;
            r_val <= i_cell_value;
        end
    end

    // Bank select: r_sel names the bank holding the current generation.
    logic r_sel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (i_cmd.flip) begin
            r_sel <= ~r_sel;
        end
    end

    // Position checks.
    logic [IDX_W-1:0] col_w, row_w;
    logic             in_grid, wr_ok;
    assign col_w   = IDX_W'(r_col);
    assign row_w   = IDX_W'(r_row);
    assign in_grid = (col_w < IDX_W'(GRID_COLS)) && (row_w < IDX_W'(GRID_ROWS));
    assign wr_ok   = (col_w != '0) && (row_w != '0) &&
                     (col_w < IDX_W'(GRID_COLS - 1)) && (row_w < IDX_W'(GRID_ROWS - 1));

    // Read address: sequential row or neighbor row of the addressed cell.
    logic [IDX_W-1:0] nbr_sum;
    logic             nbr_zero, rd_zero, rd_en;
    logic [AW-1:0]    rd_addr;
    assign nbr_sum  = row_w + i_cmd.cnt;
    assign nbr_zero = (nbr_sum == '0) || (nbr_sum > IDX_W'(GRID_ROWS));
    assign rd_zero  = i_cmd.rd_nbr && nbr_zero;
    assign rd_en    = (i_cmd.rd_seq || i_cmd.rd_nbr) && !rd_zero;
    assign rd_addr  = i_cmd.rd_seq ? AW'(i_cmd.cnt) : AW'(nbr_sum - IDX_W'(1));

    // Grid banks, one row per entry.
    logic [GRID_COLS-1:0] mem0 [GRID_ROWS];
    logic [GRID_COLS-1:0] mem1 [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd0, r_rd1;

    logic [GRID_COLS-1:0] cur_rd, prev_rd, cell_row, gen_row, wr_data;
    logic [AW-1:0]        wr_addr;
    logic                 we0, we1, gen_we, cell_we;

    assign cur_rd  = r_sel ? r_rd1 : r_rd0;
    assign prev_rd = r_sel ? r_rd0 : r_rd1;

    // Write port selection for both banks.
    always_comb begin
        gen_we  = i_cmd.wr_gen;
        cell_we = i_cmd.wr_cell && wr_ok;
        we0 = i_cmd.clr || (gen_we && r_sel) || (cell_we && !r_sel);
        we1 = i_cmd.clr || (gen_we && !r_sel) || (cell_we && r_sel);
        if (i_cmd.clr) begin
            wr_addr = AW'(i_cmd.cnt);
            wr_data = '0;
        end else if (gen_we) begin
            wr_addr = AW'(i_cmd.cnt - IDX_W'(3));
            wr_data = gen_row;
        end else begin
            wr_addr = AW'(r_row);
            wr_data = cell_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= mem0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd1 <= mem1[rd_addr];
        end
    end

    // Row with the addressed cell replaced by the written value.
    always_comb begin
        cell_row = cur_rd;
        for (int j = 0; j < GRID_COLS; j++) begin
            if (IDX_W'(j) == col_w) begin
                cell_row[j] = r_val;
            end
        end
    end

    // Three-row windows; rows outside the grid enter as dead.
    logic                 r_rd_vld, r_rd_zero;
    logic [GRID_COLS-1:0] r_cw [3];
    logic [GRID_COLS-1:0] r_pw [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_seq || i_cmd.rd_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_zero <= rd_zero;
        if (r_rd_vld) begin
            r_cw[0] <= r_cw[1];
            r_cw[1] <= r_cw[2];
            r_cw[2] <= r_rd_zero ? '0 : cur_rd;
            r_pw[0] <= r_pw[1];
            r_pw[1] <= r_pw[2];
            r_pw[2] <= r_rd_zero ? '0 : prev_rd;
        end
    end

    // Next-generation row from the current window, rule B3/S23.
    always_comb begin
        logic [3:0] n;
        gen_row = '0;
        for (int j = 1; j < GRID_COLS - 1; j++) begin
            n = count8({r_cw[0][j-1], r_cw[0][j], r_cw[0][j+1],
                        r_cw[1][j-1], r_cw[1][j+1],
                        r_cw[2][j-1], r_cw[2][j], r_cw[2][j+1]});
            gen_row[j] = (n == 4'd3) || (r_cw[1][j] && (n == 4'd2));
        end
    end

    // Neighborhood of the addressed cell in both generations.
    logic [PW-1:0] c0s, c1s, c2s, p0s, p1s, p2s;
    logic [3:0]    cur_n, prev_n;
    logic          cur_a, prev_a;
    assign c0s = {1'b0, r_cw[0], 1'b0} >> r_col;
    assign c1s = {1'b0, r_cw[1], 1'b0} >> r_col;
    assign c2s = {1'b0, r_cw[2], 1'b0} >> r_col;
    assign p0s = {1'b0, r_pw[0], 1'b0} >> r_col;
    assign p1s = {1'b0, r_pw[1], 1'b0} >> r_col;
    assign p2s = {1'b0, r_pw[2], 1'b0} >> r_col;
    assign cur_n  = count8({c0s[2:0], c1s[2], c1s[0], c2s[2:0]});
    assign prev_n = count8({p0s[2:0], p1s[2], p1s[0], p2s[2:0]});
    assign cur_a  = c1s[1];
    assign prev_a = p1s[1];

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_op == OP_READ && in_grid) begin
                o_alive           <= cur_a;
                o_neighbour_count <= cur_n;
                o_changed         <= (cur_a != prev_a) || (cur_n != prev_n);
                if (!cur_a) begin
                    o_colour_class <= CLS_DEAD;
                end else if (cur_n == 4'd2) begin
                    o_colour_class <= CLS_TWO;
                end else if (cur_n == 4'd3) begin
                    o_colour_class <= CLS_THREE;
                end else begin
                    o_colour_class <= CLS_OTHER;
                end
            end else begin
                o_alive           <= 1'b0;
                o_neighbour_count <= '0;
                o_colour_class    <= CLS_DEAD;
                o_changed         <= 1'b0;
            end
        end
    end
endmodule

[hw/rtl/life_automaton_grid_engine_top.sv]
// Top level of the life grid engine: controller, datapath and channel ports.
//
//  Channel | Dir | Payload                                           | Handshake
//  i_in    | in  | operation, col, row, cell_value                   | valid/ready
//  o_out   | out | alive, neighbour_count, colour_class, changed     | valid/ready
//
// One item is in work at a time. A write fetches the addressed row and
// writes it back; a read fetches the three rows around the cell. An advance
// reads one row of the current bank per cycle through a three-row window,
// and each new row is written to the other bank, which then becomes current.
// After reset a clearing pass zeroes both banks row by row before the first beat
// is taken. A stalled result beat holds in the output register; the next input
// beat is still taken, and its result waits until that register is free.
module life_automaton_grid_engine_top #(
    parameter int GRID_COLS = 160,
    parameter int GRID_ROWS = 120
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lage_in_if.sink    i_in,
    lage_out_if.source o_out
);
    import lage_pkg::*;

    t_dp_cmd cmd;

    lage_ctrl #(
        .GRID_ROWS (GRID_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    lage_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (i_in.operation),
        .i_col             (i_in.col),
        .i_row             (i_in.row),
        .i_cell_value      (i_in.cell_value),
        .o_alive           (o_out.alive),
        .o_neighbour_count (o_out.neighbour_count),
        .o_colour_class    (o_out.colour_class),
        .o_changed         (o_out.changed)
    );

    // The input is not ready in the cycle after an accepted beat.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken twice in a row");

    // The colour class is dead exactly when the cell is dead.
    a_class_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.colour_class == CLS_DEAD) == !o_out.alive))
        else $error("colour class disagrees with cell state");

    // A cell has at most eight neighbors.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.neighbour_count <= 4'd8))
        else $error("neighbor count out of range");
endmodule

[sim/tb_top.sv]
// Testbench for the life grid engine: directed table plus random items, checked by a grid model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lage_pkg::*;

    localparam int COLS = 160;
    localparam int ROWS = 120;
    localparam int CYCLE_LIMIT = 2000000;

    // Operation code that the block leaves unused.
    localparam t_op OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] col;
        logic [6:0] row;
        logic       val;
    } t_cmd;

    typedef struct packed {
        logic       alive;
        logic [3:0] nbrs;
        t_cls       cls;
        logic       changed;
    } t_report;

    // One directed row: the command and, where known, the report it must give.
    typedef struct packed {
        t_cmd    cmd;
        logic    fixed;
        t_report rpt;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    lage_in_if  in_ch();
    lage_out_if out_ch();

    life_automaton_grid_engine_top #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Grid copies kept by the predictor.
    bit      now_grid [ROWS][COLS];
    bit      old_grid [ROWS][COLS];
    t_report reports_due[$];
    int      fail_count = 0;
    int      reads_seen = 0;
    int      cycle_count = 0;

    function automatic bit cell_of(const ref bit g [ROWS][COLS], input int r, input int c);
        if (r < 0 || c < 0 || r >= ROWS || c >= COLS) return 1'b0;
        return g[r][c];
    endfunction

    function automatic int live_nbrs(const ref bit g [ROWS][COLS], input int r, input int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0) n += cell_of(g, r + dr, c + dc);
        return n;
    endfunction

    // Apply one command to the grid copies and give the report it produces.
    function automatic t_report life_step(input t_cmd cmd);
        t_report rpt;
        int n, pn;
        bit a, pa;
        rpt = '0;
        case (cmd.op)
            OP_WRITE: begin
                if (cmd.col >= 1 && cmd.row >= 1 && cmd.col < COLS - 1 && cmd.row < ROWS - 1)
                    now_grid[cmd.row][cmd.col] = cmd.val;
            end
            OP_ADVANCE: begin
                old_grid = now_grid;
                for (int r = 1; r < ROWS - 1; r++)
                    for (int c = 1; c < COLS - 1; c++) begin
                        n = live_nbrs(old_grid, r, c);
                        now_grid[r][c] = (n == 3) || (old_grid[r][c] && n == 2);
                    end
            end
            OP_READ: begin
                if (cmd.col < COLS && cmd.row < ROWS) begin
                    a  = now_grid[cmd.row][cmd.col];
                    n  = live_nbrs(now_grid, cmd.row, cmd.col);
                    pa = old_grid[cmd.row][cmd.col];
                    pn = live_nbrs(old_grid, cmd.row, cmd.col);
                    rpt.alive = a;
                    rpt.nbrs = 4'(n);
                    rpt.cls = !a ? CLS_DEAD : (n == 2 ? CLS_TWO : (n == 3 ? CLS_THREE : CLS_OTHER));
                    rpt.changed = (a != pa) || (n != pn);
                end
            end
            default: ;
        endcase
        return rpt;
    endfunction

    // Send one beat after a random gap, then record its expected report.
    // Valid stays high across a zero gap and drops only when a gap follows.
    task automatic send_cmd(input t_cmd cmd, input bit fixed, input t_report rpt);
        t_report guess;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= cmd.op;
        in_ch.col <= cmd.col;
        in_ch.row <= cmd.row;
        in_ch.cell_value <= cmd.val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        guess = life_step(cmd);
        if (fixed && guess !== rpt) begin
            $error("directed row disagrees with model: row %0d col %0d", cmd.row, cmd.col);
            fail_count++;
        end
        reports_due.push_back(fixed ? rpt : guess);
    endtask

    function automatic t_cmd make_cmd(input int op, input int c, input int r, input int v);
        t_cmd cmd;
        cmd.op = 2'(op); cmd.col = 8'(c); cmd.row = 7'(r); cmd.val = 1'(v);
        return cmd;
    endfunction

    // Result side: random stalls and field checks.
    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $error("result beat with no expectation");
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (out_ch.alive !== want.alive) begin
                        $error("alive: expected %0d actual %0d", want.alive, out_ch.alive);
                        fail_count++;
                    end
                    if (out_ch.neighbour_count !== want.nbrs) begin
                        $error("neighbour_count: expected %0d actual %0d",
                               want.nbrs, out_ch.neighbour_count);
                        fail_count++;
                    end
                    if (out_ch.colour_class !== want.cls) begin
                        $error("colour_class: expected %0d actual %0d",
                               want.cls, out_ch.colour_class);
                        fail_count++;
                    end
                    if (out_ch.changed !== want.changed) begin
                        $error("changed: expected %0d actual %0d", want.changed, out_ch.changed);
                        fail_count++;
                    end
                    if (want.alive || want.nbrs != 0) reads_seen++;
                end
            end
            if ($urandom_range(0, 19) == 0) out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 2) != 0) out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus: directed table, then random patterns and noise.
    initial begin
        t_row    plan[$];
        t_row    item;
        t_cmd    cmd;
        int      r0, c0, pick;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.col = '0;
        in_ch.row = '0;
        in_ch.cell_value = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fresh grid reads, border writes, out-of-grid, unused code, blinker.
        plan.push_back('{make_cmd(OP_READ, 0, 0, 0), 1'b1, '0});
        plan.push_back('{make_cmd(OP_READ, 159, 119, 0), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 0, 5, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 159, 5, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 5, 0, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 5, 119, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 255, 127, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_READ, 255, 127, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_READ, 5, 0, 0), 1'b1, '0});
        plan.push_back('{make_cmd(OP_SPARE, 170, 85, 1), 1'b1, '0});
        plan.push_back('{make_cmd(OP_WRITE, 157, 117, 1), 1'b0, '0});
        plan.push_back('{make_cmd(OP_WRITE, 158, 118, 1), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 159, 119, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_WRITE, 10, 10, 1), 1'b0, '0});
        plan.push_back('{make_cmd(OP_WRITE, 11, 10, 1), 1'b0, '0});
        plan.push_back('{make_cmd(OP_WRITE, 12, 10, 1), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 11, 10, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_ADVANCE, 0, 0, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 11, 9, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 10, 10, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_WRITE, 11, 11, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 11, 10, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_ADVANCE, 0, 0, 0), 1'b0, '0});
        plan.push_back('{make_cmd(OP_READ, 11, 10, 0), 1'b0, '0});
        foreach (plan[i]) begin
            item = plan[i];
            send_cmd(item.cmd, item.fixed, item.rpt);
        end
        in_ch.valid <= 1'b0;

        // Hold off until every report has arrived.
        while (reports_due.size() != 0) @(posedge i_clk);

        // Random: seed a small patch, advance a few times and probe around it.
        for (int k = 0; k < 80; k++) begin
            pick = $urandom_range(0, 19);
            r0 = $urandom_range(1, ROWS - 6);
            c0 = $urandom_range(1, COLS - 6);
            if (pick < 6) begin
                cmd = make_cmd(OP_WRITE, c0 + $urandom_range(0, 3) % 4,
                               r0 % 8 + 20, $urandom_range(0, 3) != 0);
                cmd.col = 8'(20 + $urandom_range(0, 6));
            end else if (pick < 8) begin
                cmd = make_cmd(OP_ADVANCE, $urandom_range(0, 255), $urandom_range(0, 127),
                               $urandom_range(0, 1));
            end else if (pick < 16) begin
                cmd = make_cmd(OP_READ, 18 + $urandom_range(0, 10), 18 + $urandom_range(0, 12),
                               $urandom_range(0, 1));
            end else if (pick < 18) begin
                cmd = make_cmd($urandom_range(0, 3), $urandom_range(0, 255),
                               $urandom_range(0, 127), $urandom_range(0, 1));
            end else begin
                cmd = make_cmd($urandom_range(0, 1) ? OP_READ : OP_WRITE, c0, r0,
                               $urandom_range(0, 1));
            end
            send_cmd(cmd, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (ROWS + 20) @(posedge i_clk);
        $display("Covered reset reads, border and out-of-grid writes, unused code, a blinker,");
        $display("and random patches with %0d nonzero reads over %0d cycles.",
                 reads_seen, cycle_count);
        if (fail_count == 0 && reports_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
